### design/lcg_pkg.sv
// shared types, constants and sine table for the linear chirp generator
`timescale 1ns / 1ps

package lcg_pkg;

    localparam int TABLE_BITS  = 10;
    localparam int OUT_BITS    = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int QUARTER     = 2 ** (TABLE_BITS - 2);
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    localparam int START_BITS  = 32;
    localparam int PHASE_BITS  = 32;
    localparam int STEP_BITS   = 48;
    localparam int FRAC_BITS   = STEP_BITS - PHASE_BITS;
    localparam int AMP_BITS    = 16;
    localparam int COUNT_BITS  = 25;
    localparam int INDEX_BITS  = 24;
    localparam int CFG_DATA_BITS  = 48;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [AMP_BITS-1:0]   AMP_FULL    = AMP_BITS'(32768);
    localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(1024);

    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
    localparam longint          ONE_Q30    = 64'sd1073741824;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_START_STEP   = 2'd0,
        CFG_STEP_DELTA   = 2'd1,
        CFG_AMPLITUDE    = 2'd2,
        CFG_SAMPLE_COUNT = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [START_BITS-1:0] start_step;
        logic [STEP_BITS-1:0]  step_delta;
        logic [AMP_BITS-1:0]   amplitude;
        logic [COUNT_BITS-1:0] sample_count;
    } lcg_cfg_t;

    // one queued word: table address of the sample and the end-of-sweep flag
    typedef struct packed {
        logic [TABLE_BITS-1:0] addr;
        logic                  last;
    } lcg_word_t;

    typedef logic [OUT_BITS-2:0] mag_t;
    typedef mag_t qsin_table_t [QUARTER+1];

    // quarter-wave magnitude from a fixed-point taylor series, elaboration only
    function automatic mag_t quarter_sine(input int q);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned amp_max;
        longint          sum;
        begin
            amp_max = (64'd1 << (OUT_BITS - 1)) - 64'd1;
            x    = (longint'(q) * TWO_PI_Q30) >> TABLE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            term = ((term * x2) >> 30) / 6;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 20;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 42;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 72;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 110;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 156;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 210;
            sum  = sum - longint'(term);
            if (sum < 0)
            begin
                sum = 0;
            end
            if (sum > ONE_Q30)
            begin
                sum = ONE_Q30;
            end
            return mag_t'((longint'(sum) * longint'(amp_max) + (64'sd1 <<< 29)) >>> 30);
        end
    endfunction

    function automatic qsin_table_t build_qsin();
        qsin_table_t t;
        begin
            for (int i = 0; i <= QUARTER; i++)
            begin
                t[i] = quarter_sine(i);
            end
            return t;
        end
    endfunction

    localparam qsin_table_t QSIN_TABLE = build_qsin();

endpackage

### design/lcg_front.sv
// front end: accepts words, advances phase, step and sweep index
`timescale 1ns / 1ps

module lcg_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                restart,
    input  lcg_pkg::lcg_cfg_t   cfg,
    input  logic                queue_full,
    output logic                push,
    output lcg_pkg::lcg_word_t  push_word
);
    import lcg_pkg::*;

    logic [PHASE_BITS-1:0] phase_acc_reg, phase_acc_next;
    logic [STEP_BITS-1:0]  step_fine_reg, step_fine_next;
    logic [INDEX_BITS-1:0] sample_index_reg, sample_index_next;

    logic [PHASE_BITS-1:0] phase_base;
    logic [STEP_BITS-1:0]  step_base;
    logic [INDEX_BITS-1:0] index_base;
    logic [PHASE_BITS-1:0] phase_new;
    logic [STEP_BITS-1:0]  step_load;
    logic [INDEX_BITS-1:0] final_index;
    logic                  last;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    assign step_load = {cfg.start_step, {FRAC_BITS{1'b0}}};

    // index of the final sample: count clamped to 1 .. 2^24, minus one
    always_comb
    begin
        if (cfg.sample_count[COUNT_BITS-1])
        begin
            final_index = {INDEX_BITS{1'b1}};
        end
        else if (cfg.sample_count[INDEX_BITS-1:0] == '0)
        begin
            final_index = '0;
        end
        else
        begin
            final_index = cfg.sample_count[INDEX_BITS-1:0] - INDEX_BITS'(1);
        end
    end

    always_comb
    begin
        if (restart)
        begin
            phase_base = '0;
            step_base  = step_load;
            index_base = '0;
        end
        else
        begin
            phase_base = phase_acc_reg;
            step_base  = step_fine_reg;
            index_base = sample_index_reg;
        end
        phase_new = phase_base + step_base[STEP_BITS-1:FRAC_BITS];
        last      = index_base >= final_index;
    end

    always_comb
    begin
        phase_acc_next    = phase_acc_reg;
        step_fine_next    = step_fine_reg;
        sample_index_next = sample_index_reg;
        if (push)
        begin
            if (last)
            begin
                phase_acc_next    = '0;
                step_fine_next    = step_load;
                sample_index_next = '0;
            end
            else
            begin
                phase_acc_next    = phase_new;
                step_fine_next    = step_base + cfg.step_delta;
                sample_index_next = index_base + INDEX_BITS'(1);
            end
        end
    end

    assign push_word.addr = phase_new[PHASE_BITS-1 -: TABLE_BITS];
    assign push_word.last = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg    <= '0;
            step_fine_reg    <= '0;
            sample_index_reg <= '0;
        end
        else
        begin
            phase_acc_reg    <= phase_acc_next;
            step_fine_reg    <= step_fine_next;
            sample_index_reg <= sample_index_next;
        end
    end

endmodule

### design/lcg_queue.sv
// short word queue between front and back end
`timescale 1ns / 1ps

module lcg_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lcg_pkg::lcg_word_t  push_word,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output lcg_pkg::lcg_word_t  pop_word
);
    import lcg_pkg::*;

    lcg_word_t mem [QUEUE_DEPTH];

    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_BITS:0]   count_reg, count_next;

    assign full      = count_reg == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_word  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + QUEUE_PTR_BITS'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QUEUE_PTR_BITS'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + (QUEUE_PTR_BITS+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QUEUE_PTR_BITS+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/lcg_back.sv
// back end: sine table lookup, amplitude scaling, output register
`timescale 1ns / 1ps

module lcg_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        word_valid,
    input  lcg_pkg::lcg_word_t          word,
    output logic                        pop,
    input  logic [lcg_pkg::AMP_BITS-1:0] amplitude,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [lcg_pkg::SAMPLE_BITS-1:0] in_phase,
    output logic [lcg_pkg::SAMPLE_BITS-1:0] quadrature,
    output logic                        last_sample
);
    import lcg_pkg::*;

    localparam int PROD_BITS = OUT_BITS + AMP_BITS + 1;
    localparam logic [TABLE_BITS-2:0] QUARTER_Q   = (TABLE_BITS-1)'(QUARTER);
    localparam logic [TABLE_BITS-1:0] QUARTER_ADR = TABLE_BITS'(QUARTER);
    localparam logic signed [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) <<< (OUT_BITS - 2);
    localparam logic signed [PROD_BITS-1:0] SAT_HI = PROD_BITS'(32767);
    localparam logic signed [PROD_BITS-1:0] SAT_LO = -PROD_BITS'(32768);

    // full-wave table value from the quarter-wave table
    function automatic logic signed [OUT_BITS-1:0] rom_value(input logic [TABLE_BITS-1:0] k);
        logic [1:0]            quad;
        logic [TABLE_BITS-2:0] r;
        logic [TABLE_BITS-2:0] q;
        logic [OUT_BITS-1:0]   mag;
        begin
            quad = k[TABLE_BITS-1 -: 2];
            r    = {1'b0, k[TABLE_BITS-3:0]};
            q    = quad[0] ? (QUARTER_Q - r) : r;
            mag  = {1'b0, QSIN_TABLE[q]};
            return quad[1] ? -$signed(mag) : $signed(mag);
        end
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] scale(input logic [AMP_BITS-1:0] amp,
                                                     input logic signed [OUT_BITS-1:0] v);
        logic signed [PROD_BITS-1:0] prod;
        logic signed [PROD_BITS-1:0] rounded;
        logic [SAMPLE_BITS-1:0]      res;
        begin
            prod    = $signed({1'b0, amp}) * v;
            rounded = (prod + ROUND_HALF) >>> (OUT_BITS - 1);
            if (rounded > SAT_HI)
            begin
                res = SAT_HI[SAMPLE_BITS-1:0];
            end
            else if (rounded < SAT_LO)
            begin
                res = SAT_LO[SAMPLE_BITS-1:0];
            end
            else
            begin
                res = rounded[SAMPLE_BITS-1:0];
            end
            return res;
        end
    endfunction

    logic                       a_valid_reg;
    logic signed [OUT_BITS-1:0] a_sin_reg;
    logic signed [OUT_BITS-1:0] a_cos_reg;
    logic                       a_last_reg;
    logic                       b_valid_reg;
    logic [SAMPLE_BITS-1:0]     b_i_reg;
    logic [SAMPLE_BITS-1:0]     b_q_reg;
    logic                       b_last_reg;

    logic                  b_en;
    logic                  a_en;
    logic [AMP_BITS-1:0]   amp_eff;

    assign b_en    = !b_valid_reg || out_ready;
    assign a_en    = !a_valid_reg || b_en;
    assign pop     = word_valid && a_en;
    assign amp_eff = (amplitude > AMP_FULL) ? AMP_FULL : amplitude;

    assign out_valid   = b_valid_reg;
    assign in_phase    = b_i_reg;
    assign quadrature  = b_q_reg;
    assign last_sample = b_last_reg;

    always_ff @(posedge clk)
    begin
        if (a_en && word_valid)
        begin
            a_sin_reg  <= rom_value(word.addr);
            a_cos_reg  <= rom_value(word.addr + QUARTER_ADR);
            a_last_reg <= word.last;
        end
        if (b_en && a_valid_reg)
        begin
            b_i_reg    <= scale(amp_eff, a_cos_reg);
            b_q_reg    <= scale(amp_eff, a_sin_reg);
            b_last_reg <= a_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
            begin
                a_valid_reg <= word_valid;
            end
            if (b_en)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

endmodule

### design/linear_chirp_generator.sv
// top level of the linear fm chirp generator: config registers and datapath
//
//   port group    direction  handshake            payload
//   cfg           in         cfg_write            cfg_index, cfg_data
//   in            in         in_valid / in_ready  restart
//   out           out        out_valid / out_ready in_phase, quadrature, last_sample
//
// one sample per clock sustained while out_ready is held high; a word accepted
// on in passes the queue register, the table stage and the scaling stage to out.
// the phase, step and sweep index advance together in the front end.
// reset clears the sweep state and the pipeline; no clearing pass is needed.
// a stall on out fills the two-word queue, after which in_ready drops.
`timescale 1ns / 1ps

module linear_chirp_generator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [lcg_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [lcg_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 restart,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [lcg_pkg::SAMPLE_BITS-1:0]      in_phase,
    output logic [lcg_pkg::SAMPLE_BITS-1:0]      quadrature,
    output logic                                 last_sample
);
    import lcg_pkg::*;

    lcg_cfg_t  cfg_reg, cfg_next;
    lcg_word_t push_word;
    lcg_word_t pop_word;
    logic      push;
    logic      pop;
    logic      queue_full;
    logic      queue_not_empty;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_START_STEP:   cfg_next.start_step   = cfg_data[START_BITS-1:0];
                CFG_STEP_DELTA:   cfg_next.step_delta   = cfg_data[STEP_BITS-1:0];
                CFG_AMPLITUDE:    cfg_next.amplitude    = cfg_data[AMP_BITS-1:0];
                CFG_SAMPLE_COUNT: cfg_next.sample_count = cfg_data[COUNT_BITS-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_step   <= '0;
            cfg_reg.step_delta   <= '0;
            cfg_reg.amplitude    <= AMP_FULL;
            cfg_reg.sample_count <= COUNT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lcg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .restart    (restart),
        .cfg        (cfg_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_word  (push_word)
    );

    lcg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .pop_word  (pop_word)
    );

    lcg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .word_valid  (queue_not_empty),
        .word        (pop_word),
        .pop         (pop),
        .amplitude   (cfg_reg.amplitude),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .in_phase    (in_phase),
        .quadrature  (quadrature),
        .last_sample (last_sample)
    );

endmodule

### design/lcg_checker.sv
// port-level checks for the linear chirp generator, bound to the top level
`timescale 1ns / 1ps

module lcg_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 cfg_write,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic [lcg_pkg::SAMPLE_BITS-1:0]      in_phase,
    input logic [lcg_pkg::SAMPLE_BITS-1:0]      quadrature,
    input logic                                 last_sample
);
    import lcg_pkg::*;

    // words in flight: queue plus table stage plus output register
    localparam int PEND_MAX  = QUEUE_DEPTH + 2;
    localparam int PEND_BITS = $clog2(PEND_MAX + 1);

    logic [PEND_BITS-1:0] pending_reg, pending_next;
    logic                 in_acc;
    logic                 out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
        begin
            pending_next = pending_reg + PEND_BITS'(1);
        end
        else if (out_acc && !in_acc)
        begin
            pending_next = pending_reg - PEND_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(in_phase)
            && $stable(quadrature) && $stable(last_sample))
        else $error("output word changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("output word without an accepted input word");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= PEND_BITS'(PEND_MAX))
        else $error("more words in flight than the pipeline holds");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == '0 |-> in_ready)
        else $error("input stalled with nothing in flight");

    // user writes registers only while the pipeline is empty; unenforced
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |-> pending_reg == '0)
        else $error("register write with words in flight");

endmodule

bind linear_chirp_generator lcg_checker u_lcg_checker (.*);
